FILE: src/fbpa_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths of the fixed block pool allocator.
// No dependencies; every other file of the block imports this package.

package fbpa_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;

    localparam int ADDR_W    = 40;
    localparam int BASE_W    = 32;
    localparam int SIZE_W    = 16;
    localparam int COUNT_W   = 11;
    localparam int USED_W    = 11;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int CMD_BITS  = 3;

    localparam logic [BASE_W-1:0]  BASE_RST  = 32'd65536;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd64;
    localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;
    localparam logic [USED_W-1:0]  USED_MAX  = 11'h7FF;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    // input actions
    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REBUILD = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BOUNDS     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULL       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    // classified commands passed from the front end to the stack engine
    typedef enum logic [CMD_BITS-1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_NULL,
        CMD_BOUNDS,
        CMD_REBUILD,
        CMD_NOP
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   free_address;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_address;
        logic [USED_W-1:0]   used_blocks;
    } out_item_t;

endpackage

FILE: src/fbpa_fifo.sv
`timescale 1ns / 1ps
// Small first-in first-out queue with valid/ready on both sides.
// Depends on fbpa_pkg for the default width (the result item).

module fbpa_fifo
    import fbpa_pkg::*;
#(
    parameter int WIDTH = $bits(out_item_t),
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             wr_fire;
    logic             rd_fire;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_fire && !rd_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_fire && !wr_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: src/fbpa_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the free alignment check.
// Depends on fbpa_pkg for the divisor width.

module fbpa_div
    import fbpa_pkg::*;
#(
    parameter int W = SIZE_W + $clog2(MAX_BLOCKS_DEF + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [W-1:0]      dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [SIZE_W-1:0] remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [W-1:0]      quo_reg;
    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   trial;
    logic              fits;
    logic [SIZE_W-1:0] rem_next;

    // shift in the next dividend bit, subtract when the divisor fits
    assign shifted  = {rem_reg, quo_reg[W-1]};
    assign trial    = shifted - {1'b0, divisor};
    assign fits     = (shifted >= {1'b0, divisor});
    assign rem_next = fits ? trial[SIZE_W-1:0] : shifted[SIZE_W-1:0];

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

endmodule

FILE: src/fbpa_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions and classifies them into commands.
// Depends on fbpa_pkg for the item types and command codes.

module fbpa_front
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int DEP_W = $clog2(MAX_BLOCKS + 1),
    localparam int OFF_W = SIZE_W + DEP_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  in_item_t          in_item,
    input  logic [BASE_W-1:0] base_address,
    input  logic [SIZE_W-1:0] block_size,
    input  logic [DEP_W-1:0]  live_count,
    output logic              q_valid,
    input  logic              q_ready,
    output cmd_t              q_cmd,
    output logic [OFF_W-1:0]  q_offset
);

    localparam int EXT_W = ADDR_W + 1;

    logic              s1_valid_reg;
    in_item_t          s1_item_reg;
    logic              s2_valid_reg;
    in_item_t          s2_item_reg;
    logic [OFF_W-1:0]  s2_span_reg;
    logic [OFF_W-1:0]  span_next;
    logic              s1_adv;
    logic              s2_adv;
    logic              accept;
    logic [EXT_W-1:0]  start_ext;
    logic [EXT_W-1:0]  end_ext;
    logic [EXT_W-1:0]  addr_ext;
    logic [ADDR_W-1:0] offset_full;
    logic              out_of_pool;

    assign s2_adv = !s2_valid_reg || q_ready;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign full   = !s1_adv;
    assign accept = push && s1_adv;

    // pool span in bytes, registered ahead of the bounds compare
    assign span_next = OFF_W'(block_size) * OFF_W'(live_count);

    assign start_ext   = EXT_W'(base_address);
    assign end_ext     = start_ext + EXT_W'(s2_span_reg);
    assign addr_ext    = EXT_W'(s2_item_reg.free_address);
    assign offset_full = s2_item_reg.free_address - ADDR_W'(base_address);
    assign out_of_pool = (addr_ext < start_ext) || (addr_ext >= end_ext) ||
                         (block_size == '0);

    assign q_valid  = s2_valid_reg;
    assign q_offset = offset_full[OFF_W-1:0];

    always_comb
    begin
        case (s2_item_reg.action)
            ACT_ALLOC:   q_cmd = CMD_ALLOC;
            ACT_FREE:
            begin
                if (s2_item_reg.free_address == '0)
                begin
                    q_cmd = CMD_NULL;
                end
                else if (out_of_pool)
                begin
                    q_cmd = CMD_BOUNDS;
                end
                else
                begin
                    q_cmd = CMD_FREE;
                end
            end
            ACT_REBUILD: q_cmd = CMD_REBUILD;
            default:     q_cmd = CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= push;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s2_adv)
        begin
            s2_item_reg <= s1_item_reg;
            s2_span_reg <= span_next;
        end
    end

endmodule

FILE: src/fbpa_back.sv
`timescale 1ns / 1ps
// Back end: free stack memory, depth and use counters, and the command sequencer.
// Depends on fbpa_pkg and instantiates fbpa_div.

module fbpa_back
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int DEP_W  = $clog2(MAX_BLOCKS + 1),
    localparam int IDX_W  = $clog2(MAX_BLOCKS),
    localparam int OFF_W  = SIZE_W + DEP_W,
    localparam int PROD_W = IDX_W + SIZE_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  cmd_t              q_cmd,
    input  logic [OFF_W-1:0]  q_offset,
    input  logic [BASE_W-1:0] base_address,
    input  logic [SIZE_W-1:0] block_size,
    input  logic [DEP_W-1:0]  live_count,
    output logic              res_valid,
    input  logic              res_ready,
    output out_item_t         res_item
);

    localparam int RST_COUNT = int'(COUNT_RST);
    localparam logic [DEP_W-1:0] DEPTH_MAX = DEP_W'(MAX_BLOCKS);
    localparam logic [DEP_W-1:0] DEPTH_RST =
        (RST_COUNT > MAX_BLOCKS) ? DEP_W'(MAX_BLOCKS) : DEP_W'(RST_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCALE,
        S_DIV,
        S_REPLY
    } state_t;

    state_t            state_reg;
    logic [DEP_W-1:0]  depth_reg;
    logic [DEP_W-1:0]  low_reg;
    logic [USED_W-1:0] used_reg;
    logic              pop_hit_reg;
    logic [IDX_W-1:0]  pop_addr_reg;
    logic [PROD_W-1:0] prod_reg;
    out_item_t         res_reg;

    logic [IDX_W-1:0]  stack_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]  rd_data_reg;

    logic              take;
    logic [DEP_W-1:0]  depth_dec;
    logic [IDX_W-1:0]  pop_addr;
    logic              pop_hit_next;
    logic [IDX_W-1:0]  pop_index;
    logic [PROD_W-1:0] scaled;
    logic [ADDR_W-1:0] alloc_addr;
    logic [USED_W-1:0] used_inc;
    logic [USED_W-1:0] used_dec;
    logic              div_start;
    logic              div_done;
    logic [OFF_W-1:0]  div_quo;
    logic [SIZE_W-1:0] div_rem;
    logic              mem_we;

    assign q_ready   = (state_reg == S_IDLE);
    assign take      = q_valid && q_ready;
    assign res_valid = (state_reg == S_REPLY);
    assign res_item  = res_reg;

    // Entries below the low-water mark still hold their rebuild value (the
    // index itself); everything at or above it was pushed since the rebuild.
    assign depth_dec    = depth_reg - 1'b1;
    assign pop_addr     = depth_dec[IDX_W-1:0];
    assign pop_hit_next = (depth_dec < low_reg);
    assign pop_index    = pop_hit_reg ? pop_addr_reg : rd_data_reg;

    assign scaled     = PROD_W'(pop_index) * PROD_W'(block_size);
    assign alloc_addr = ADDR_W'(base_address) + ADDR_W'(prod_reg);

    assign used_inc = (used_reg == USED_MAX) ? used_reg : used_reg + 1'b1;
    assign used_dec = (used_reg == '0) ? used_reg : used_reg - 1'b1;

    assign div_start = take && (q_cmd == CMD_FREE);
    assign mem_we    = (state_reg == S_DIV) && div_done && (div_rem == '0) &&
                       (depth_reg != DEPTH_MAX);

    fbpa_div #(
        .W (OFF_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (q_offset),
        .divisor   (block_size),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= div_quo[IDX_W-1:0];
        end
        rd_data_reg <= stack_mem[pop_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            depth_reg    <= DEPTH_RST;
            low_reg      <= DEPTH_RST;
            used_reg     <= '0;
            pop_hit_reg  <= 1'b0;
            pop_addr_reg <= '0;
            prod_reg     <= '0;
            res_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        case (q_cmd)
                            CMD_ALLOC:
                            begin
                                if (depth_reg == '0)
                                begin
                                    res_reg   <= '{ST_EXHAUSTED, '0, used_reg};
                                    state_reg <= S_REPLY;
                                end
                                else
                                begin
                                    depth_reg    <= depth_dec;
                                    pop_addr_reg <= pop_addr;
                                    pop_hit_reg  <= pop_hit_next;
                                    if (pop_hit_next)
                                    begin
                                        low_reg <= depth_dec;
                                    end
                                    state_reg <= S_POP;
                                end
                            end
                            CMD_FREE:
                            begin
                                state_reg <= S_DIV;
                            end
                            CMD_NULL:
                            begin
                                res_reg   <= '{ST_NULL, '0, used_reg};
                                state_reg <= S_REPLY;
                            end
                            CMD_BOUNDS:
                            begin
                                res_reg   <= '{ST_BOUNDS, '0, used_reg};
                                state_reg <= S_REPLY;
                            end
                            CMD_REBUILD:
                            begin
                                depth_reg <= live_count;
                                low_reg   <= live_count;
                                used_reg  <= '0;
                                res_reg   <= '{ST_OK, '0, '0};
                                state_reg <= S_REPLY;
                            end
                            default:
                            begin
                                res_reg   <= '{ST_OK, '0, used_reg};
                                state_reg <= S_REPLY;
                            end
                        endcase
                    end
                end
                S_POP:
                begin
                    prod_reg  <= scaled;
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    used_reg  <= used_inc;
                    res_reg   <= '{ST_OK, alloc_addr, used_inc};
                    state_reg <= S_REPLY;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (div_rem != '0)
                        begin
                            res_reg <= '{ST_MISALIGNED, '0, used_reg};
                        end
                        else if (depth_reg == DEPTH_MAX)
                        begin
                            res_reg <= '{ST_FULL, '0, used_reg};
                        end
                        else
                        begin
                            depth_reg <= depth_reg + 1'b1;
                            used_reg  <= used_dec;
                            res_reg   <= '{ST_OK, '0, used_dec};
                        end
                        state_reg <= S_REPLY;
                    end
                end
                S_REPLY:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/fixed_block_pool_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the fixed block pool allocator: configuration registers,
// front end, command queue, stack engine and result queue.
// Depends on fbpa_pkg, fbpa_front, fbpa_fifo, fbpa_back (and fbpa_div below it).
//
//   Channel   Dir  Handshake               Payload
//   input     in   push high, full low     in_item   (action, free_address)
//   result    out  pop high, empty low     out_item  (status, block_address, used_blocks)
//   config    in   cfg_write high          cfg_index, cfg_data
//
// Flow: the front end registers each transaction, then bounds-checks and
// classifies it. The stack engine then runs an allocate through memory read,
// scale, add and reply; a free inside the pool waits on the restoring divider,
// which yields one quotient bit per cycle, before its reply; the rest reply
// directly. Reset: no clearing pass; a low-water mark over the free stack
// lets reset and rebuild just set the stack depth and the mark. Stalls: a
// held pop parks the result queue, and the command queue lets the front end
// keep accepting until the command queue fills as well.

module fixed_block_pool_allocator_unit
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             in_item,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            out_item,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DEP_W  = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W  = SIZE_W + DEP_W;
    localparam int CMP_W  = (DEP_W > COUNT_W) ? DEP_W : COUNT_W;
    localparam int CQ_W   = CMD_BITS + OFF_W;
    localparam int RQ_W   = $bits(out_item_t);

    logic [BASE_W-1:0]  base_address_reg;
    logic [SIZE_W-1:0]  block_size_reg;
    logic [COUNT_W-1:0] block_count_reg;

    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   live_wide;
    logic [DEP_W-1:0]   live_count;

    logic               fq_valid;
    logic               fq_ready;
    cmd_t               fq_cmd;
    logic [OFF_W-1:0]   fq_offset;
    logic [CQ_W-1:0]    cq_data;
    logic               bq_valid;
    logic               bq_ready;
    cmd_t               bq_cmd;
    logic [OFF_W-1:0]   bq_offset;

    logic               res_valid;
    logic               res_ready;
    out_item_t          res_item;
    logic               rq_valid;
    logic [RQ_W-1:0]    rq_data;

    // Configuration writes land at once; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg <= BASE_RST;
            block_size_reg   <= SIZE_RST;
            block_count_reg  <= COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE:  base_address_reg <= cfg_data;
                CFG_SIZE:  block_size_reg   <= cfg_data[SIZE_W-1:0];
                CFG_COUNT: block_count_reg  <= cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Clamp the configured count to the stack capacity.
    assign count_ext  = CMP_W'(block_count_reg);
    assign live_wide  = (count_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : count_ext;
    assign live_count = live_wide[DEP_W-1:0];

    fbpa_front #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .in_item      (in_item),
        .base_address (base_address_reg),
        .block_size   (block_size_reg),
        .live_count   (live_count),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_cmd        (fq_cmd),
        .q_offset     (fq_offset)
    );

    // Command queue between classification and execution.
    fbpa_fifo #(
        .WIDTH (CQ_W),
        .DEPTH (2)
    ) u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  ({fq_cmd, fq_offset}),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (cq_data)
    );

    assign bq_cmd    = cmd_t'(cq_data[OFF_W +: CMD_BITS]);
    assign bq_offset = cq_data[OFF_W-1:0];

    fbpa_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (bq_valid),
        .q_ready      (bq_ready),
        .q_cmd        (bq_cmd),
        .q_offset     (bq_offset),
        .base_address (base_address_reg),
        .block_size   (block_size_reg),
        .live_count   (live_count),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_item     (res_item)
    );

    // Result queue: holds finished transactions until popped.
    fbpa_fifo #(
        .WIDTH (RQ_W),
        .DEPTH (2)
    ) u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_ready (res_ready),
        .wr_data  (RQ_W'(res_item)),
        .rd_valid (rq_valid),
        .rd_ready (pop),
        .rd_data  (rq_data)
    );

    assign empty    = !rq_valid;
    assign out_item = out_item_t'(rq_data);

endmodule

FILE: src/fbpa_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg for the item types and status codes.

module fbpa_checker
    import fbpa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input out_item_t out_item
);

    // leaving reset: no result waits and the input side is open
    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
        else $error("queue not clean after reset");

    // any failed transaction reports a null address
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_item.status != ST_OK)) |-> (out_item.block_address == '0))
        else $error("address reported on a failed transaction");

    // a handed-out block is counted as in use
    a_alloc_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (out_item.status == ST_OK) && (out_item.block_address != '0))
            |-> (out_item.used_blocks != '0))
        else $error("allocation left the use count at zero");

    // a result that is not popped stays put
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("waiting result changed or vanished");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fixed_block_pool_allocator_unit: directed and random
// allocate, free and rebuild transactions, each reply checked against a pool model.
// Depends on fbpa_pkg and the allocator RTL; reads and writes no files.

module tb;
    import fbpa_pkg::*;

    localparam int     CLK_PERIOD   = 12;
    localparam int     RESET_CYCLES = 5;
    localparam int     MAX_GAP      = 17;
    // Worst case through the block is the front end plus the divider.
    localparam int     DRAIN_CYCLES = 40;
    localparam longint LIMIT_CYCLES = 1000000;
    localparam int     POOL_DEPTH   = MAX_BLOCKS_DEF;
    localparam int     IDX_W        = $clog2(POOL_DEPTH);
    localparam int     MAX_PRINTS   = 50;
    // The block ignores this action code; the package leaves it unnamed.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    in_item_t             in_item   = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    out_item_t            out_item;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // ------------------------------------------------------------------
    // Pool model state: registers, free stack of block indices, counters
    // ------------------------------------------------------------------
    logic [BASE_W-1:0]  pool_base;
    logic [SIZE_W-1:0]  pool_size;
    logic [COUNT_W-1:0] pool_count;
    logic [IDX_W-1:0]   free_idx [POOL_DEPTH];
    logic [COUNT_W-1:0] free_depth;
    logic [USED_W-1:0]  used_count;

    // Replies predicted at acceptance, oldest first
    out_item_t          pending_replies [$];
    // Addresses handed out and not yet returned; feeds well-formed frees
    logic [ADDR_W-1:0]  held_blocks [$];

    // Idle control shared by the sender and the result checker
    bit tx_gaps_on     = 1'b1;
    bit rx_gaps_on     = 1'b1;
    int rx_hold_cycles = 0;

    // Bookkeeping
    int mismatches      = 0;
    int results_checked = 0;
    int input_stalls    = 0;
    int rx_holds        = 0;
    int reg_writes      = 0;
    int status_hits [0:ST_FULL];

    always #(CLK_PERIOD / 2) clk = ~clk;

    fixed_block_pool_allocator_unit #(
        .MAX_BLOCKS (MAX_BLOCKS_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------

    // Counts above the stack capacity act as a full-capacity pool.
    function automatic int unsigned live_blocks();
        return (pool_count > POOL_DEPTH) ? POOL_DEPTH : pool_count;
    endfunction

    function automatic logic [ADDR_W-1:0] block_addr(longint unsigned k);
        return ADDR_W'(64'(pool_base) + k * 64'(pool_size));
    endfunction

    // Refill the stack in ascending order so the highest block pops first.
    function automatic void rebuild_pool();
        int unsigned n;
        n = live_blocks();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            free_idx[i] = (i < n) ? IDX_W'(i) : '0;
        end
        free_depth = COUNT_W'(n);
        used_count = '0;
    endfunction

    // Advance the model by one accepted transaction and return its reply.
    function automatic out_item_t predict_reply(in_item_t it);
        out_item_t        r;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [63:0]      addr;
        logic [63:0]      off;
        logic [IDX_W-1:0] idx;
        r = '0;
        r.status = ST_OK;
        case (it.action)
            ACT_ALLOC:
            begin
                if (free_depth == 0)
                begin
                    r.status = ST_EXHAUSTED;
                end
                else
                begin
                    free_depth = free_depth - 1'b1;
                    idx = free_idx[free_depth[IDX_W-1:0]];
                    r.block_address = block_addr(idx);
                    if (used_count < USED_MAX)
                    begin
                        used_count = used_count + 1'b1;
                    end
                end
            end
            ACT_FREE:
            begin
                lo   = 64'(pool_base);
                hi   = lo + 64'(pool_size) * 64'(live_blocks());
                addr = 64'(it.free_address);
                if (addr == 0)
                begin
                    r.status = ST_NULL;
                end
                else if (addr < lo || addr >= hi || pool_size == 0)
                begin
                    r.status = ST_BOUNDS;
                end
                else
                begin
                    off = addr - lo;
                    if (off % 64'(pool_size) != 0)
                    begin
                        r.status = ST_MISALIGNED;
                    end
                    else if (free_depth >= POOL_DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        // Double frees are not caught: push the index again.
                        free_idx[free_depth[IDX_W-1:0]] = IDX_W'(off / 64'(pool_size));
                        free_depth = free_depth + 1'b1;
                        if (used_count > 0)
                        begin
                            used_count = used_count - 1'b1;
                        end
                    end
                end
            end
            ACT_REBUILD:
            begin
                rebuild_pool();
            end
            default:
            begin
            end
        endcase
        r.used_blocks = used_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_item_t make_item(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr);
        in_item_t it;
        it.action       = act;
        it.free_address = addr;
        return it;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // Mostly allocate and return real blocks; mix in double frees, bad
    // addresses, nulls, ignored codes and the odd rebuild.
    function automatic in_item_t random_request();
        in_item_t    it;
        int unsigned pick;
        int unsigned k;
        int unsigned live;
        live = live_blocks();
        it   = make_item(ACT_ALLOC, random_address());
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            it.action = ACT_ALLOC;
        end
        else if (pick < 80 && held_blocks.size() != 0)
        begin
            k = $urandom_range(0, held_blocks.size() - 1);
            it = make_item(ACT_FREE, held_blocks[k]);
            held_blocks.delete(k);
        end
        else if (pick < 86)
        begin
            // Any block start; often a block that is already free.
            k  = $urandom % ((live != 0) ? live : 1);
            it = make_item(ACT_FREE, block_addr(k));
        end
        else if (pick < 90 && pool_size > 1)
        begin
            k  = $urandom % ((live != 0) ? live : 1);
            it = make_item(ACT_FREE, block_addr(k) + $urandom_range(1, pool_size - 1));
        end
        else if (pick < 94)
        begin
            case ($urandom_range(0, 2))
                0:       it = make_item(ACT_FREE, random_address());
                1:       it = make_item(ACT_FREE, block_addr(live) + $urandom_range(0, 3));
                default: it = make_item(ACT_FREE, ADDR_W'(pool_base) - 1'b1);
            endcase
        end
        else if (pick < 96)
        begin
            it = make_item(ACT_FREE, '0);
        end
        else if (pick < 98)
        begin
            it.action = ACT_UNUSED;
        end
        else
        begin
            it.action = ACT_REBUILD;
        end
        return it;
    endfunction

    // Offer one transaction, hold it until accepted, then record its reply.
    // Push stays high on return so a back-to-back item needs no new edge.
    task automatic send_item(in_item_t it);
        out_item_t reply;
        int        gap;
        gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do
        begin
            @(posedge clk);
            if (full)
            begin
                input_stalls++;
            end
        end
        while (full);
        reply = predict_reply(it);
        pending_replies = {pending_replies, reply};
        if (it.action == ACT_ALLOC && reply.status == ST_OK)
        begin
            held_blocks = {held_blocks, reply.block_address};
        end
        else if (it.action == ACT_REBUILD)
        begin
            held_blocks.delete();
        end
    endtask

    // Drop push, wait for every outstanding reply, then let the pipeline empty.
    task automatic settle_pool();
        push <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Only call while idle; the model register follows the write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_BASE:  pool_base  = value[BASE_W-1:0];
            CFG_SIZE:  pool_size  = value[SIZE_W-1:0];
            CFG_COUNT: pool_count = value[COUNT_W-1:0];
            default:
            begin
            end
        endcase
        reg_writes++;
    endtask

    task automatic configure_pool(logic [BASE_W-1:0] base, logic [SIZE_W-1:0] size,
                                  logic [COUNT_W-1:0] count);
        settle_pool();
        write_reg(CFG_BASE, CFG_W'(base));
        write_reg(CFG_SIZE, CFG_W'(size));
        write_reg(CFG_COUNT, CFG_W'(count));
    endtask

    task automatic report_error(string msg);
        if (mismatches < MAX_PRINTS)
        begin
            $display("ERROR: reply %0d: %s", results_checked, msg);
        end
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset pool: 1024 blocks of 64 bytes at 65536, stack completely full.
    task automatic test_reset_pool();
        send_item(make_item(ACT_FREE, block_addr(0)));       // refused, stack full
        send_item(make_item(ACT_ALLOC, '0));                  // highest block first
        send_item(make_item(ACT_ALLOC, '0));
        send_item(make_item(ACT_FREE, block_addr(1023)));
        send_item(make_item(ACT_FREE, block_addr(1023)));    // double free, used drops to 0
        send_item(make_item(ACT_FREE, block_addr(1023)));    // stack full again
        send_item(make_item(ACT_ALLOC, '0));                  // last pushed comes back
        send_item(make_item(ACT_REBUILD, '0));
    endtask

    task automatic test_free_checks();
        send_item(make_item(ACT_FREE, '0));
        send_item(make_item(ACT_FREE, ADDR_W'(pool_base) - 1'b1));
        send_item(make_item(ACT_FREE, block_addr(live_blocks())));
        send_item(make_item(ACT_FREE, block_addr(5) + 1'b1));
        send_item(make_item(ACT_FREE, '1));
        send_item(make_item(ACT_UNUSED, '1));
    endtask

    // A new count bounds frees at once; the old stack serves until the next rebuild.
    task automatic test_register_change();
        settle_pool();
        write_reg(CFG_COUNT, CFG_W'(2));
        send_item(make_item(ACT_ALLOC, '0));
        send_item(make_item(ACT_FREE, block_addr(1022)));    // now past the end
        send_item(make_item(ACT_REBUILD, '0));
        send_item(make_item(ACT_ALLOC, '0));
        send_item(make_item(ACT_ALLOC, '0));
        send_item(make_item(ACT_ALLOC, '0));                  // exhausted
    endtask

    // Zero count, zero size and a count beyond capacity.
    task automatic test_degenerate_pool();
        settle_pool();
        write_reg(CFG_COUNT, CFG_W'(0));
        send_item(make_item(ACT_REBUILD, '0));
        send_item(make_item(ACT_ALLOC, '0));
        settle_pool();
        write_reg(CFG_SIZE, CFG_W'(0));
        write_reg(CFG_COUNT, CFG_W'(4));
        send_item(make_item(ACT_REBUILD, '0));
        send_item(make_item(ACT_FREE, ADDR_W'(pool_base)));  // pool spans no bytes
        send_item(make_item(ACT_ALLOC, '0));
        settle_pool();
        write_reg(CFG_SIZE, CFG_W'(8));
        write_reg(CFG_COUNT, CFG_W'(2047));
        send_item(make_item(ACT_ALLOC, '0));                  // new size applies at once
        send_item(make_item(ACT_REBUILD, '0));
        send_item(make_item(ACT_ALLOC, '0));
        send_item(make_item(ACT_FREE, block_addr(1023)));
    endtask

    task automatic test_random_phase(logic [BASE_W-1:0] base, logic [SIZE_W-1:0] size,
                                     logic [COUNT_W-1:0] count, int n_items);
        int unsigned mode;
        configure_pool(base, size, count);
        send_item(make_item(ACT_REBUILD, '0));
        for (int i = 0; i < n_items; i++)
        begin
            // Reshuffle idling now and then; keep some stretches gap-free.
            if (i % 60 == 0)
            begin
                mode = $urandom_range(0, 5);
                tx_gaps_on = (mode != 0 && mode != 1);
                rx_gaps_on = (mode != 0 && mode != 2);
            end
            send_item(random_request());
        end
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Stop draining replies for a long stretch while pushing flat out, so both
    // internal queues fill and full rises.
    task automatic test_backpressure();
        configure_pool(32'h0000_2000, 16'd48, 11'd6);
        send_item(make_item(ACT_REBUILD, '0));
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = 600;
        for (int i = 0; i < 150; i++)
        begin
            send_item(random_request());
        end
        tx_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checker: pop with random hold-offs, compare with oldest reply
    // ------------------------------------------------------------------
    initial
    begin : result_checker
        out_item_t got;
        out_item_t want;
        int        wait_cycles;
        wait (rst_n === 1'b1);
        forever
        begin
            wait_cycles = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold_cycles > 0)
            begin
                wait_cycles += rx_hold_cycles;
                rx_hold_cycles = 0;
                rx_holds++;
            end
            if (wait_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            pop <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (empty !== 1'b0);
            // Sampled at the accepting edge, before any update from it.
            got = out_item;
            if (pending_replies.size() == 0)
            begin
                report_error($sformatf("unexpected reply, status %0d address 0x%0h",
                                       got.status, got.block_address));
            end
            else
            begin
                want = pending_replies.pop_front();
                results_checked++;
                status_hits[want.status]++;
                if (got.status !== want.status)
                begin
                    report_error($sformatf("status %0d, expected %0d",
                                           got.status, want.status));
                end
                if (got.block_address !== want.block_address)
                begin
                    report_error($sformatf("block_address 0x%0h, expected 0x%0h",
                                           got.block_address, want.block_address));
                end
                if (got.used_blocks !== want.used_blocks)
                begin
                    report_error($sformatf("used_blocks %0d, expected %0d",
                                           got.used_blocks, want.used_blocks));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        foreach (status_hits[s])
        begin
            status_hits[s] = 0;
        end
        pool_base  = BASE_RST;
        pool_size  = SIZE_RST;
        pool_count = COUNT_RST;
        rebuild_pool();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_pool();
        test_free_checks();
        test_register_change();
        test_degenerate_pool();

        test_random_phase(32'd65536, 16'd64, 11'd8, 350);
        test_random_phase(32'd1, 16'd1, 11'd1, 150);
        test_random_phase(32'hFFFF_FFFF, 16'hFFFF, 11'd1024, 250);
        test_random_phase($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(2, 700),
                          $urandom_range(2, 40), 400);
        test_backpressure();
        test_random_phase($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1, 16'hFFFF),
                          11'd1500, 200);
        test_random_phase(32'h0040_0000, 16'd3, 11'd5, 300);

        settle_pool();
        if (pending_replies.size() != 0)
        begin
            report_error("replies still outstanding at end of run");
        end
        $display("Checked %0d replies over %0d register writes;", results_checked, reg_writes);
        $display("%0d input stall cycles, %0d long hold-offs.", input_stalls, rx_holds);
        $display("Status mix: %0d ok, %0d exhausted, %0d out of bounds,",
                 status_hits[ST_OK], status_hits[ST_EXHAUSTED], status_hits[ST_BOUNDS]);
        $display("%0d misaligned, %0d null, %0d stack full.",
                 status_hits[ST_MISALIGNED], status_hits[ST_NULL], status_hits[ST_FULL]);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d replies outstanding.", pending_replies.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
